>>> rtl/deadline_profit_job_scheduler_core_macros.svh
// Assertion helpers for the job scheduler
`ifndef DEADLINE_PROFIT_JOB_SCHEDULER_CORE_MACROS_SVH
`define DEADLINE_PROFIT_JOB_SCHEDULER_CORE_MACROS_SVH
// implication checked on every clock edge outside reset
`define DPJS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define DPJS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> rtl/dpjs_pkg.sv
// ----------------------------------------------------------------------------
// dpjs_pkg
// Shared payload types for the deadline/profit job scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package dpjs_pkg;
    typedef struct packed {
        logic [7:0]  job_id;
        logic [15:0] job_deadline;
        logic [15:0] job_profit;
        logic        last_job;
    } job_t;

    typedef struct packed {
        logic [5:0]  slot_index;
        logic        slot_used;
        logic [7:0]  slot_job_id;
        logic [15:0] slot_profit;
        logic [6:0]  scheduled_count;
        logic [21:0] total_profit;
        logic        jobs_dropped;
        logic        last_result;
    } slot_res_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] deadline;
        logic [15:0] profit;
    } entry_t;
endpackage
`default_nettype wire

>>> rtl/dpjs_if.sv
// ----------------------------------------------------------------------------
// dpjs_job_if / dpjs_res_if
// Valid/ready channels for job beats and slot result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface dpjs_job_if;
    logic           valid;
    logic           ready;
    dpjs_pkg::job_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface dpjs_res_if;
    logic                valid;
    logic                ready;
    dpjs_pkg::slot_res_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> rtl/deadline_profit_job_scheduler_core.sv
// Flow: after the last job beat, each stored job leaves the cell chain in S_PICK
// and then probes slots in S_PROBE, from one slot up to min(deadline, job count)
// slots (none for deadline 0); once S_PICK finds the chain empty, the first result
// beat passes through the read register and the output register. Throughput: one
// job beat per cycle while loading, then one result beat per cycle while the sink is
// ready; job input stalls from the last job beat until the last result beat is registered.
// ----------------------------------------------------------------------------
// deadline_profit_job_scheduler_core
// Job sequencing with deadlines: sorted load chain, slot search, readout.
// Reset clears the cell chain valid bits, slot flags and counters at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module deadline_profit_job_scheduler_core #(
    parameter int MAX_JOBS = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    dpjs_job_if.sink  job_in,
    dpjs_res_if.source res_out
);
    import dpjs_pkg::*;
    `include "deadline_profit_job_scheduler_core_macros.svh"

    localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CW = $clog2(MAX_JOBS + 1);

    typedef enum logic [2:0] {S_LOAD, S_PICK, S_PROBE, S_OUT} state_t;

    state_t           state_reg;
    logic [CW-1:0]    cnt_reg;
    logic             ovf_reg;
    logic [IW-1:0]    lim_reg;
    logic [CW-1:0]    oidx_reg;
    logic [6:0]       sched_reg;
    logic [21:0]      tot_reg;
    logic [MAX_JOBS-1:0] taken_reg;
    entry_t           cur_reg;
    entry_t           owner_mem [MAX_JOBS];
    entry_t           rd_ent;
    logic             out_vld_reg;
    slot_res_t        out_reg;

    logic             ins, shf, clr;
    logic             c_take [MAX_JOBS+1];
    logic             c_vld  [MAX_JOBS+2];
    entry_t           c_ent  [MAX_JOBS+2];
    entry_t           new_ent;

    logic          rd_used_reg;
    logic [CW-1:0] rd_idx_reg;
    logic          rd_vld_reg;
    logic          take_out;
    logic          rd_adv;
    logic          out_load;
    logic          rd_last;

    assign new_ent = '{id: job_in.payload.job_id, deadline: job_in.payload.job_deadline,
                       profit: job_in.payload.job_profit};
    assign job_in.ready = (state_reg == S_LOAD);
    assign ins = job_in.valid && job_in.ready && (cnt_reg < CW'(MAX_JOBS));
    assign c_take[0] = 1'b0;
    assign c_vld[0] = 1'b0;
    assign c_ent[0] = new_ent;
    assign c_vld[MAX_JOBS+1] = 1'b0;
    assign c_ent[MAX_JOBS+1] = new_ent;
    assign clr = 1'b0;
    assign shf = (state_reg == S_PICK);

    genvar g;
    generate
        for (g = 0; g < MAX_JOBS; g++)
        begin : g_cell
            dpjs_sort_cell u_cell (
                .clk(clk), .rst_n(rst_n), .clear(clr), .insert(ins), .shift(shf),
                .new_ent(new_ent), .prv_take(c_take[g]),
                .prv_vld(c_vld[g]), .prv_ent(c_ent[g]),
                .nxt_vld(c_vld[g+2]), .nxt_ent(c_ent[g+2]),
                .take(c_take[g+1]), .vld(c_vld[g+1]), .ent(c_ent[g+1])
            );
        end
    endgenerate

    logic          fin;
    logic [IW-1:0] start;
    assign fin = job_in.valid && job_in.ready && job_in.payload.last_job;

    always_comb
    begin
        start = '0;
        if (c_ent[1].deadline >= 16'(cnt_reg))
        begin
            start = IW'(cnt_reg - 1'b1);
        end
        else
        begin
            start = IW'(c_ent[1].deadline - 16'd1);
        end
    end

    assign take_out = !out_vld_reg || res_out.ready;
    assign rd_adv   = (state_reg == S_OUT) && (take_out || !rd_vld_reg);
    assign out_load = rd_adv && rd_vld_reg;
    assign rd_last  = (rd_idx_reg == cnt_reg - 1'b1);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_PROBE && !taken_reg[lim_reg])
        begin
            owner_mem[lim_reg] <= cur_reg;
        end
        if (rd_adv)
        begin
            rd_ent <= owner_mem[oidx_reg[IW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_LOAD;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            taken_reg   <= '0;
            oidx_reg    <= '0;
            sched_reg   <= '0;
            tot_reg     <= '0;
            out_vld_reg <= 1'b0;
            out_reg     <= '0;
            cur_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            lim_reg     <= '0;
            rd_used_reg <= 1'b0;
            rd_idx_reg  <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (res_out.ready)
            begin
                out_vld_reg <= 1'b0;
            end
            unique case (state_reg)
                S_LOAD:
                begin
                    if (job_in.valid)
                    begin
                        if (ins)
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (fin)
                        begin
                            state_reg <= S_PICK;
                        end
                    end
                end
                S_PICK:
                begin
                    // head of the chain leaves; skip jobs that cannot fit
                    cur_reg <= c_ent[1];
                    lim_reg <= start;
                    if (!c_vld[1])
                    begin
                        state_reg <= S_OUT;
                        oidx_reg  <= '0;
                        rd_vld_reg <= 1'b0;
                    end
                    else if (c_ent[1].deadline != 16'd0)
                    begin
                        state_reg <= S_PROBE;
                    end
                end
                S_PROBE:
                begin
                    if (!taken_reg[lim_reg])
                    begin
                        taken_reg[lim_reg] <= 1'b1;
                        state_reg <= S_PICK;
                    end
                    else if (lim_reg == '0)
                    begin
                        state_reg <= S_PICK;
                    end
                    else
                    begin
                        lim_reg <= lim_reg - 1'b1;
                    end
                end
                S_OUT:
                begin
                    if (rd_adv)
                    begin
                        if (rd_vld_reg)
                        begin
                            out_reg.slot_index  <= 6'(rd_idx_reg);
                            out_reg.slot_used   <= rd_used_reg;
                            out_reg.slot_job_id <= rd_used_reg ? rd_ent.id : 8'd0;
                            out_reg.slot_profit <= rd_used_reg ? rd_ent.profit : 16'd0;
                            out_reg.last_result <= rd_last;
                            out_reg.scheduled_count <= rd_last ?
                                (sched_reg + 7'(rd_used_reg)) : 7'd0;
                            out_reg.total_profit <= rd_last ? (tot_reg +
                                (rd_used_reg ? 22'(rd_ent.profit) : 22'd0)) : 22'd0;
                            out_reg.jobs_dropped <= rd_last ? ovf_reg : 1'b0;
                            if (rd_last)
                            begin
                                state_reg <= S_LOAD;
                                cnt_reg   <= '0;
                                ovf_reg   <= 1'b0;
                                taken_reg <= '0;
                                sched_reg <= '0;
                                tot_reg   <= '0;
                                rd_vld_reg <= 1'b0;
                            end
                            else
                            begin
                                sched_reg <= sched_reg + 7'(rd_used_reg);
                                tot_reg <= tot_reg +
                                    (rd_used_reg ? 22'(rd_ent.profit) : 22'd0);
                            end
                        end
                        if (!(rd_vld_reg && rd_last))
                        begin
                            if (oidx_reg < cnt_reg)
                            begin
                                rd_vld_reg  <= 1'b1;
                                rd_idx_reg  <= oidx_reg;
                                rd_used_reg <= taken_reg[oidx_reg[IW-1:0]];
                                oidx_reg    <= oidx_reg + 1'b1;
                            end
                            else
                            begin
                                rd_vld_reg <= 1'b0;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign res_out.valid   = out_vld_reg;
    assign res_out.payload = out_reg;

    `DPJS_ASSERT_IMP(a_no_load_busy, clk, rst_n, state_reg != S_LOAD, !job_in.ready,
        "job accepted outside load")
    `DPJS_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CW'(MAX_JOBS),
        "load count past capacity")
    `DPJS_ASSERT_NXT(a_hold_out, clk, rst_n, out_vld_reg && !res_out.ready,
        out_vld_reg && $stable(out_reg), "result beat changed while stalled")
    `DPJS_ASSERT_IMP(a_chain_room, clk, rst_n, ins,
        !(c_vld[MAX_JOBS] && c_take[MAX_JOBS]), "entry pushed off the chain tail")
endmodule
`default_nettype wire

>>> rtl/dpjs_sort_cell.sv
// ----------------------------------------------------------------------------
// dpjs_sort_cell
// One cell of the insertion chain: compares the new entry with its own, takes
// it where it first wins and moves down behind a cell that took; shifts toward
// the head during drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dpjs_sort_cell (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             clear,
    input  wire logic             insert,
    input  wire logic             shift,
    input  wire dpjs_pkg::entry_t new_ent,
    input  wire logic             prv_take,
    input  wire logic             prv_vld,
    input  wire dpjs_pkg::entry_t prv_ent,
    input  wire logic             nxt_vld,
    input  wire dpjs_pkg::entry_t nxt_ent,
    output logic                  take,
    output logic                  vld,
    output dpjs_pkg::entry_t      ent
);
    import dpjs_pkg::*;

    logic   vld_reg, vld_next;
    entry_t ent_reg, ent_next;

    // strict greater keeps earlier loads ahead on ties
    assign take = !vld_reg || (new_ent.profit > ent_reg.profit);

    always_comb
    begin
        vld_next = vld_reg;
        ent_next = ent_reg;
        if (clear)
        begin
            vld_next = 1'b0;
        end
        else if (shift)
        begin
            vld_next = nxt_vld;
            ent_next = nxt_ent;
        end
        else if (insert)
        begin
            if (prv_take)
            begin
                vld_next = prv_vld;
                ent_next = prv_ent;
            end
            else if (take)
            begin
                vld_next = 1'b1;
                ent_next = new_ent;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign vld = vld_reg;
    assign ent = ent_reg;
endmodule
`default_nettype wire
